// File: rtl/rlepid_pkg.sv
// ----------------------------------------------------------------------------
// rlepid_pkg
// Types and constants shared by the run-length pixel image decoder modules.
// ----------------------------------------------------------------------------
package rlepid_pkg;

   // Parser phase; codes that are never entered act as control-byte wait
   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_CONTROL = 3'd1,
      PH_PIXLO   = 3'd2,
      PH_PIXHI   = 3'd3
   } phase_type;

   // Result kinds
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;

   // Header byte positions
   localparam logic [1:0] HDR_WIDTH_LO  = 2'd0;
   localparam logic [1:0] HDR_WIDTH_HI  = 2'd1;
   localparam logic [1:0] HDR_HEIGHT_LO = 2'd2;
   localparam logic [1:0] HDR_HEIGHT_HI = 2'd3;

   // Control byte fields
   localparam int unsigned RUN_REPEAT_BIT = 7;
   localparam logic [7:0]  RUN_LEN_MASK   = 8'h7F;
   localparam int unsigned ORDER_BIT      = 7;   // bit 15 of height, in high byte

   // One input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } item_type;

   // One result item
   typedef struct packed {
      logic        kind;
      logic [15:0] pixel;
      logic [7:0]  repeat_res;
      logic [15:0] width;
      logic [14:0] height;
      logic        flip_rows;
   } result_type;

endpackage

// File: rtl/rlepid_in_stage.sv
// ----------------------------------------------------------------------------
// rlepid_in_stage
// Input register: captures one byte item and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module rlepid_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rlepid_pkg::item_type req_item,
   output logic                 item_valid,
   output rlepid_pkg::item_type item,
   input  logic                 item_take
);

   logic                 valid_ff, valid_in;
   rlepid_pkg::item_type item_ff;

   // Accept when empty or when the held item leaves this cycle
   assign req_ready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/rlepid_parser.sv
// ----------------------------------------------------------------------------
// rlepid_parser
// Header and run parser: one byte per cycle while its result can be stored;
// updates the parse state and forms at most one result for the output register.
// ----------------------------------------------------------------------------
module rlepid_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  rlepid_pkg::item_type   item,
   output logic                   item_take,
   input  logic                   out_ready,
   output logic                   res_valid,
   output rlepid_pkg::result_type res
);

   rlepid_pkg::phase_type phase_ff, phase_in, phase_eff;
   logic [1:0]            hcount_ff, hcount_in, hcount_eff;
   logic [7:0]            run_left_ff, run_left_in, run_left_eff;
   logic                  run_rep_ff, run_rep_in, run_rep_eff;
   logic [7:0]            low_hold_ff, low_hold_in;
   logic [15:0]           width_hold_ff, width_hold_in;
   logic [7:0]            hlow_hold_ff, hlow_hold_in;
   logic [7:0]            b;
   logic [7:0]            run_left_dec;

   assign b            = item.data_byte;
   assign run_left_dec = run_left_eff - 8'd1;

   // Frame start drops the run in progress and restarts the header
   always_comb begin
      phase_eff    = phase_ff;
      hcount_eff   = hcount_ff;
      run_left_eff = run_left_ff;
      run_rep_eff  = run_rep_ff;
      if (item.frame_start) begin
         phase_eff    = rlepid_pkg::PH_HEADER;
         hcount_eff   = rlepid_pkg::HDR_WIDTH_LO;
         run_left_eff = 8'd0;
         run_rep_eff  = 1'b0;
      end
   end

   // Decode the byte and compute next state and result
   always_comb begin
      phase_in      = phase_eff;
      hcount_in     = hcount_eff;
      run_left_in   = run_left_eff;
      run_rep_in    = run_rep_eff;
      low_hold_in   = low_hold_ff;
      width_hold_in = width_hold_ff;
      hlow_hold_in  = hlow_hold_ff;
      res_valid     = 1'b0;
      res           = '0;
      unique case (phase_eff)
         rlepid_pkg::PH_HEADER: begin
            unique case (hcount_eff)
               rlepid_pkg::HDR_WIDTH_LO: begin
                  width_hold_in = {8'd0, b};
                  hcount_in     = rlepid_pkg::HDR_WIDTH_HI;
               end
               rlepid_pkg::HDR_WIDTH_HI: begin
                  width_hold_in = {b, width_hold_ff[7:0]};
                  hcount_in     = rlepid_pkg::HDR_HEIGHT_LO;
               end
               rlepid_pkg::HDR_HEIGHT_LO: begin
                  hlow_hold_in = b;
                  hcount_in    = rlepid_pkg::HDR_HEIGHT_HI;
               end
               default: begin
                  res_valid     = 1'b1;
                  res.kind      = rlepid_pkg::KIND_HEADER;
                  res.width     = width_hold_ff;
                  res.height    = {b[6:0], hlow_hold_ff};
                  res.flip_rows = !b[rlepid_pkg::ORDER_BIT];
                  hcount_in     = rlepid_pkg::HDR_WIDTH_LO;
                  phase_in      = rlepid_pkg::PH_CONTROL;
               end
            endcase
         end
         rlepid_pkg::PH_PIXLO: begin
            low_hold_in = b;
            phase_in    = rlepid_pkg::PH_PIXHI;
         end
         rlepid_pkg::PH_PIXHI: begin
            res_valid = 1'b1;
            res.kind  = rlepid_pkg::KIND_PIXEL;
            res.pixel = {b, low_hold_ff};
            if (run_rep_eff) begin
               res.repeat_res = run_left_eff;
               run_left_in    = 8'd0;
               phase_in       = rlepid_pkg::PH_CONTROL;
            end else begin
               res.repeat_res = 8'd1;
               run_left_in    = run_left_dec;
               phase_in       = (run_left_dec == 8'd0) ? rlepid_pkg::PH_CONTROL
                                                       : rlepid_pkg::PH_PIXLO;
            end
         end
         default: begin
            // control byte, also any unused phase code
            run_rep_in  = b[rlepid_pkg::RUN_REPEAT_BIT];
            run_left_in = (b & rlepid_pkg::RUN_LEN_MASK) + 8'd1;
            phase_in    = rlepid_pkg::PH_PIXLO;
         end
      endcase
   end

   // Consume the byte unless its result cannot be stored yet
   assign item_take = item_valid && (!res_valid || out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= rlepid_pkg::PH_HEADER;
         hcount_ff     <= rlepid_pkg::HDR_WIDTH_LO;
         run_left_ff   <= 8'd0;
         run_rep_ff    <= 1'b0;
         low_hold_ff   <= 8'd0;
         width_hold_ff <= 16'd0;
         hlow_hold_ff  <= 8'd0;
      end else if (item_take) begin
         phase_ff      <= phase_in;
         hcount_ff     <= hcount_in;
         run_left_ff   <= run_left_in;
         run_rep_ff    <= run_rep_in;
         low_hold_ff   <= low_hold_in;
         width_hold_ff <= width_hold_in;
         hlow_hold_ff  <= hlow_hold_in;
      end
   end

   // A header result always hands over to control-byte parsing
   a_header_to_control: assert property (@(posedge clock) disable iff (reset)
      item_take && res_valid && res.kind == rlepid_pkg::KIND_HEADER
      |=> phase_ff == rlepid_pkg::PH_CONTROL)
      else $error("header result did not move to control phase");

   // A frame start byte is always taken as the first header byte
   a_frame_start_restart: assert property (@(posedge clock) disable iff (reset)
      item_take && item.frame_start
      |=> phase_ff == rlepid_pkg::PH_HEADER && hcount_ff == rlepid_pkg::HDR_WIDTH_HI)
      else $error("frame start did not restart header parsing");

   // Pixel results never carry a zero repeat count
   a_pixel_repeat_nonzero: assert property (@(posedge clock) disable iff (reset)
      item_take && res_valid && res.kind == rlepid_pkg::KIND_PIXEL
      |-> res.repeat_res != 8'd0)
      else $error("pixel result with zero repeat count");

endmodule

// File: rtl/rlepid_out_stage.sv
// ----------------------------------------------------------------------------
// rlepid_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module rlepid_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rlepid_pkg::result_type res,
   output logic                   out_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rlepid_pkg::result_type rsp_res
);

   logic                   valid_ff, valid_in;
   rlepid_pkg::result_type res_ff;

   // Room when empty or when the held result leaves this cycle
   assign out_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule

// File: rtl/rle_pixel_image_decoder.sv
// ----------------------------------------------------------------------------
// rle_pixel_image_decoder
// Run-length image decoder for 16-bit pixels, one file byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries the compressed file one byte per item;
//   req_frame_start marks the first header byte of an image. The four header
//   bytes give one header result (rsp_kind 0) with width, height and
//   flip_rows. Each later pixel gives one pixel result (rsp_kind 1) with its
//   value and repeat count; control bytes and low pixel bytes give none.
//   A byte goes from the input register through the parser into the result
//   register, which drives rsp_. Throughput: one byte per cycle unless a
//   byte with a result waits behind the full result register; the parser
//   sits between the input register and the result register.
//   Reset empties both registers and starts parsing at header byte zero.
//   When the receiver stalls, the result register holds; the parser still
//   consumes bytes that give no result, and req_ready drops only once a byte
//   with a result is waiting behind the full result register.
// ----------------------------------------------------------------------------
module rle_pixel_image_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_pixel,
   output logic [7:0]  rsp_repeat_res,
   output logic [15:0] rsp_width,
   output logic [14:0] rsp_height,
   output logic        rsp_flip_rows
);

   rlepid_pkg::item_type   req_item, item;
   rlepid_pkg::result_type res, rsp_res;
   logic                   item_valid, item_take, out_ready, res_valid;

   assign req_item.data_byte   = req_data_byte;
   assign req_item.frame_start = req_frame_start;

   rlepid_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   rlepid_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_ready  (out_ready),
      .res_valid  (res_valid),
      .res        (res)
   );

   rlepid_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (item_take && res_valid),
      .res       (res),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res)
   );

   assign rsp_kind       = rsp_res.kind;
   assign rsp_pixel      = rsp_res.pixel;
   assign rsp_repeat_res = rsp_res.repeat_res;
   assign rsp_width      = rsp_res.width;
   assign rsp_height     = rsp_res.height;
   assign rsp_flip_rows  = rsp_res.flip_rows;

endmodule
